// File: design/bet_pkg.sv
// Shared types and constants of the breakpoint envelope table.
// No dependencies; every other design file but bet_if refers to this package.
package bet_pkg;

  localparam int unsigned TABLE_DEPTH = 64;

  // Interpolation divide widths: |gain diff| (16) times frame offset (32)
  localparam int unsigned NUM_W = 48;
  localparam int unsigned DEN_W = 32;
  localparam int unsigned QUO_W = 16;

  typedef enum logic [2:0] {
    CMD_INSERT    = 3'd0,
    CMD_DEL_RANGE = 3'd1,
    CMD_INS_TIME  = 3'd2,
    CMD_DEL_TIME  = 3'd3,
    CMD_INVERT    = 3'd4,
    CMD_EVAL      = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK   = 2'd0,
    STS_DUP  = 2'd1,
    STS_FULL = 2'd2,
    STS_SAT  = 2'd3
  } sts_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHK,
    ST_SHIFT,
    ST_PLACE,
    ST_SCAN2,
    ST_MUL,
    ST_DSTART,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [31:0]        frame;
    logic [1:0]         ptype;
    logic signed [15:0] gain;
  } entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic scan;
    logic scan2;
    logic chk;
    logic shift;
    logic place;
    logic mul;
    logic div_start;
    logic finish;
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic [2:0] cmd;
    logic       done;
    logic       refuse;
    logic       div_done;
    logic       out_free;
  } stat_t;

endpackage

// File: design/bet_if.sv
// Valid/ready channel interfaces for commands and results.
// Depends on nothing but the port widths of the block.
interface bet_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic [31:0]        frame;
  logic [31:0]        count;
  logic [1:0]         type_mask;
  logic signed [15:0] gain;

  modport source (output valid, command, frame, count, type_mask, gain, input ready);
  modport sink (input valid, command, frame, count, type_mask, gain, output ready);
endinterface

interface bet_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] value;
  logic [1:0]         status;
  logic [6:0]         entries;

  modport source (output valid, value, status, entries, input ready);
  modport sink (input valid, value, status, entries, output ready);
endinterface

// File: design/breakpoint_envelope_table_unit.sv
// Breakpoint envelope table: an ordered list of up to TableDepth breakpoints (frame,
// type, Q3.12 gain) edited by insert, delete, time shift and invert commands and read
// by linear interpolation. One command is in work at a time; each returns one result.
// Each command scans the held entries with one memory read per entry (registered read
// port); insert then shifts the tail down one entry a cycle, delete time makes two
// passes, and evaluate follows its scan with one multiply and a 48-step serial divider.
// A finished result waits until the previous one has left. No clearing pass is needed
// after reset.
module breakpoint_envelope_table_unit #(
  parameter int unsigned TableDepth = bet_pkg::TABLE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       type_enable_we_i,
  input  logic [1:0] type_enable_wdata_i,
  bet_cmd_if.sink    cmd_i,
  bet_res_if.source  res_o
);
  bet_pkg::ctl_t  ctl;
  bet_pkg::stat_t stat;

  bet_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_ready_o (cmd_i.ready),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  bet_dp #(
    .TableDepth (TableDepth)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .stat_o         (stat),
    .te_we_i        (type_enable_we_i),
    .te_wdata_i     (type_enable_wdata_i),
    .in_command_i   (cmd_i.command),
    .in_frame_i     (cmd_i.frame),
    .in_count_i     (cmd_i.count),
    .in_type_mask_i (cmd_i.type_mask),
    .in_gain_i      (cmd_i.gain),
    .out_valid_o    (res_o.valid),
    .out_ready_i    (res_o.ready),
    .out_value_o    (res_o.value),
    .out_status_o   (res_o.status),
    .out_entries_o  (res_o.entries)
  );
endmodule

// File: design/bet_div.sv
// Bit-serial restoring divider for the interpolation quotient.
// Depends on bet_pkg for operand widths.
module bet_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bet_pkg::NUM_W-1:0]  num_i,
  input  logic [bet_pkg::DEN_W-1:0]  den_i,
  output logic [bet_pkg::QUO_W-1:0]  quot_o,
  output logic                       done_o
);
  localparam int unsigned CntW = $clog2(bet_pkg::NUM_W + 1);

  logic                       busy_q, done_q;
  logic [CntW-1:0]            cnt_q;
  logic [bet_pkg::NUM_W-1:0]  acc_q;
  logic [bet_pkg::DEN_W-1:0]  rem_q, den_q;
  logic [bet_pkg::DEN_W:0]    sh, diff;
  logic                       qbit;

  // One quotient bit per cycle
  always_comb begin
    sh   = {rem_q, acc_q[bet_pkg::NUM_W-1]};
    diff = sh - {1'b0, den_q};
    qbit = (sh >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(bet_pkg::NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      acc_q <= {acc_q[bet_pkg::NUM_W-2:0], qbit};
      rem_q <= qbit ? diff[bet_pkg::DEN_W-1:0] : sh[bet_pkg::DEN_W-1:0];
    end
  end

  assign quot_o = acc_q[bet_pkg::QUO_W-1:0];
  assign done_o = done_q;
endmodule

// File: design/bet_dp.sv
// Datapath: breakpoint memory, scan pipeline, interpolation and result register.
// Depends on bet_pkg and bet_div.
module bet_dp #(
  parameter int unsigned TableDepth = bet_pkg::TABLE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bet_pkg::ctl_t      ctl_i,
  output bet_pkg::stat_t     stat_o,
  input  logic               te_we_i,
  input  logic [1:0]         te_wdata_i,
  input  logic [2:0]         in_command_i,
  input  logic [31:0]        in_frame_i,
  input  logic [31:0]        in_count_i,
  input  logic [1:0]         in_type_mask_i,
  input  logic signed [15:0] in_gain_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] out_value_o,
  output logic [1:0]         out_status_o,
  output logic [6:0]         out_entries_o
);
  localparam int unsigned AW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CW = $clog2(TableDepth + 1);
  localparam int unsigned QUO_W_L = bet_pkg::QUO_W;

  bet_pkg::entry_t mem [TableDepth];

  // Item registers
  logic [2:0]         cmd_q;
  logic [31:0]        f_q, n_q;
  logic [32:0]        end_q;
  logic [1:0]         m_q, te_q;
  logic signed [15:0] g_q;

  // Scan state
  logic [CW-1:0] cnt_q, cnt_d, ridx_q, ridx_d, pidx_q, w_q, w_d, pos_q, pos_d;
  logic          vld_q, rd_en, done;
  logic          stopped_q, stopped_d, pos_found_q, pos_found_d, dup_q, dup_d;
  logic          found_n_q, found_n_d, found_p_q, found_p_d;
  logic [31:0]   fn_q, fn_d, fp_q, fp_d;
  logic signed [15:0] gn_q, gn_d, gp_q, gp_d;
  logic [1:0]    sts_q, sts_d;
  bet_pkg::entry_t rdat_q;
  logic [AW-1:0] raddr;

  // Write port
  logic            we;
  logic [AW-1:0]   wa;
  bet_pkg::entry_t wd;

  // Interpolation
  logic               ok_q, neg_q;
  logic [47:0]        mag_q;
  logic [31:0]        den_q;
  logic signed [16:0] gdiff;
  logic [16:0]        gabs;
  logic [QUO_W_L-1:0] quot;
  logic               div_done;
  logic signed [16:0] qs;
  logic signed [17:0] sum;
  logic signed [15:0] val;

  // Result register
  logic               ov_q;
  logic signed [15:0] oval_q;
  logic [1:0]         osts_q;
  logic [6:0]         oent_q;

  logic        scan_any, proc, hit, ge, past, stop_c, stop_now;
  logic [31:0] fr;
  logic [32:0] nf;

  assign scan_any = ctl_i.scan | ctl_i.scan2;
  assign rd_en    = (scan_any | ctl_i.shift) & ~done;
  assign raddr    = ctl_i.shift ? AW'(ridx_q - 1'b1) : ridx_q[AW-1:0];

  // Scan step: per-entry decisions, memory writes and next values
  always_comb begin
    fr        = rdat_q.frame;
    hit       = |(rdat_q.ptype & m_q);
    ge        = fr >= f_q;
    past      = {1'b0, fr} > end_q;
    nf        = {1'b0, fr} + {1'b0, n_q};
    proc      = vld_q & scan_any;
    stop_c    = 1'b0;
    stop_now  = stopped_q | past;
    we        = 1'b0;
    wa        = pidx_q[AW-1:0];
    wd        = rdat_q;
    w_d       = w_q;
    stopped_d = stopped_q;
    pos_d     = pos_q;
    pos_found_d = pos_found_q;
    dup_d     = dup_q;
    found_n_d = found_n_q;
    found_p_d = found_p_q;
    fn_d      = fn_q;
    gn_d      = gn_q;
    fp_d      = fp_q;
    gp_d      = gp_q;
    sts_d     = sts_q;
    cnt_d     = cnt_q;

    if (ctl_i.scan && proc) begin
      if (cmd_q == bet_pkg::CMD_INSERT) begin
        if (!pos_found_q && ge) begin
          pos_d       = pidx_q;
          pos_found_d = 1'b1;
        end
        if (hit && ge) begin
          dup_d  = (fr == f_q);
          stop_c = 1'b1;
        end
      end else if (cmd_q == bet_pkg::CMD_DEL_RANGE || cmd_q == bet_pkg::CMD_DEL_TIME) begin
        // Compact: copy kept entries down to the write pointer
        stopped_d = stop_now;
        if (stop_now || !(ge && hit)) begin
          we  = 1'b1;
          wa  = w_q[AW-1:0];
          w_d = w_q + 1'b1;
        end
      end else if (cmd_q == bet_pkg::CMD_INS_TIME) begin
        if (ge && hit) begin
          we = 1'b1;
          if (nf[32]) begin
            wd.frame = '1;
            sts_d    = bet_pkg::STS_SAT;
          end else begin
            wd.frame = nf[31:0];
          end
        end
      end else if (cmd_q == bet_pkg::CMD_INVERT) begin
        if (ge) begin
          if (past) begin
            stop_c = 1'b1;
          end else if (hit) begin
            we = 1'b1;
            if (rdat_q.gain == 16'sh8000) begin
              wd.gain = 16'sh7FFF;
              sts_d   = bet_pkg::STS_SAT;
            end else begin
              wd.gain = -rdat_q.gain;
            end
          end
        end
      end else if (cmd_q == bet_pkg::CMD_EVAL) begin
        if (hit) begin
          if (ge) begin
            found_n_d = 1'b1;
            fn_d      = fr;
            gn_d      = rdat_q.gain;
            stop_c    = 1'b1;
          end else begin
            found_p_d = 1'b1;
            fp_d      = fr;
            gp_d      = rdat_q.gain;
          end
        end
      end
    end

    // Second pass of delete time: move back, clamp at zero
    if (ctl_i.scan2 && proc && ge && hit) begin
      we       = 1'b1;
      wd.frame = (fr > n_q) ? fr - n_q : 32'd0;
    end

    // Open a gap for the new entry
    if (ctl_i.shift && vld_q) begin
      we = 1'b1;
      wa = AW'(pidx_q + 1'b1);
    end

    if (ctl_i.place) begin
      we       = 1'b1;
      wa       = pos_q[AW-1:0];
      wd.frame = f_q;
      wd.ptype = m_q;
      wd.gain  = g_q;
      cnt_d    = cnt_q + 1'b1;
    end

    if (ctl_i.chk) begin
      if (dup_q) begin
        sts_d = bet_pkg::STS_DUP;
      end else if (cnt_q == CW'(TableDepth)) begin
        sts_d = bet_pkg::STS_FULL;
      end
    end

    if (scan_any) begin
      done = vld_q ? (stop_c || (pidx_q + 1'b1) == cnt_q) : (ridx_q >= cnt_q);
    end else if (ctl_i.shift) begin
      done = (ridx_q == pos_q);
    end else begin
      done = 1'b0;
    end

    if (ctl_i.scan && done &&
        (cmd_q == bet_pkg::CMD_DEL_RANGE || cmd_q == bet_pkg::CMD_DEL_TIME)) begin
      cnt_d = w_d;
    end

    // Read pointer
    if (ctl_i.load || (scan_any && done)) begin
      ridx_d = '0;
    end else if (ctl_i.chk) begin
      ridx_d = cnt_q;
    end else if (rd_en) begin
      ridx_d = ctl_i.shift ? ridx_q - 1'b1 : ridx_q + 1'b1;
    end else begin
      ridx_d = ridx_q;
    end
  end

  // Memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rdat_q <= mem[raddr];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      te_q   <= 2'd3;
      ridx_q <= '0;
      vld_q  <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      ridx_q <= ridx_d;
      vld_q  <= rd_en;
      if (te_we_i) begin
        te_q <= te_wdata_i;
      end
      if (ctl_i.finish) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Interpolation operands
  always_comb begin
    gdiff = {gn_q[15], gn_q} - {gp_q[15], gp_q};
    gabs  = gdiff[16] ? -gdiff : gdiff;
    qs    = neg_q ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    sum   = {{2{gp_q[15]}}, gp_q} + {qs[16], qs};
    if (sum > 18'sd32767) begin
      val = 16'sh7FFF;
    end else if (sum < -18'sd32768) begin
      val = 16'sh8000;
    end else begin
      val = sum[15:0];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      pidx_q <= ctl_i.shift ? ridx_q - 1'b1 : ridx_q;
    end
    if (ctl_i.load) begin
      cmd_q       <= in_command_i;
      f_q         <= in_frame_i;
      n_q         <= in_count_i;
      end_q       <= {1'b0, in_frame_i} + {1'b0, in_count_i};
      m_q         <= in_type_mask_i;
      g_q         <= in_gain_i;
      w_q         <= '0;
      stopped_q   <= 1'b0;
      pos_q       <= cnt_q;
      pos_found_q <= 1'b0;
      dup_q       <= 1'b0;
      found_n_q   <= 1'b0;
      found_p_q   <= 1'b0;
      sts_q       <= bet_pkg::STS_OK;
    end else begin
      w_q         <= w_d;
      stopped_q   <= stopped_d;
      pos_q       <= pos_d;
      pos_found_q <= pos_found_d;
      dup_q       <= dup_d;
      found_n_q   <= found_n_d;
      found_p_q   <= found_p_d;
      sts_q       <= sts_d;
    end
    fn_q <= fn_d;
    gn_q <= gn_d;
    fp_q <= fp_d;
    gp_q <= gp_d;
    if (ctl_i.mul) begin
      ok_q  <= found_n_q & found_p_q & (|(te_q & m_q));
      neg_q <= gdiff[16];
      mag_q <= gabs[15:0] * (f_q - fp_q);
      den_q <= fn_q - fp_q;
    end
    if (ctl_i.finish) begin
      oval_q <= (cmd_q == bet_pkg::CMD_EVAL && ok_q) ? val : 16'sd0;
      osts_q <= sts_q;
      oent_q <= 7'(cnt_q);
    end
  end

  bet_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl_i.div_start),
    .num_i   (mag_q),
    .den_i   (den_q),
    .quot_o  (quot),
    .done_o  (div_done)
  );

  assign stat_o.cmd      = cmd_q;
  assign stat_o.done     = done;
  assign stat_o.refuse   = dup_q | (cnt_q == CW'(TableDepth));
  assign stat_o.div_done = div_done;
  assign stat_o.out_free = ~ov_q | out_ready_i;

  assign out_valid_o   = ov_q;
  assign out_value_o   = oval_q;
  assign out_status_o  = osts_q;
  assign out_entries_o = oent_q;
endmodule

// File: design/bet_ctrl.sv
// Controller: sequences the scan, shift, place and divide phases of a command.
// Depends on bet_pkg for states, commands and the control structs.
module bet_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bet_pkg::stat_t stat_i,
  output bet_pkg::ctl_t  ctl_o
);
  bet_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bet_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands; unknown codes walk the table without touching it
  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      bet_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d = bet_pkg::ST_SCAN;
        end
      end
      bet_pkg::ST_SCAN: begin
        ctl_o.scan = 1'b1;
        if (stat_i.done) begin
          priority if (stat_i.cmd == bet_pkg::CMD_INSERT) begin
            state_d = bet_pkg::ST_CHK;
          end else if (stat_i.cmd == bet_pkg::CMD_DEL_TIME) begin
            state_d = bet_pkg::ST_SCAN2;
          end else if (stat_i.cmd == bet_pkg::CMD_EVAL) begin
            state_d = bet_pkg::ST_MUL;
          end else begin
            state_d = bet_pkg::ST_DONE;
          end
        end
      end
      bet_pkg::ST_CHK: begin
        ctl_o.chk = 1'b1;
        state_d = stat_i.refuse ? bet_pkg::ST_DONE : bet_pkg::ST_SHIFT;
      end
      bet_pkg::ST_SHIFT: begin
        ctl_o.shift = 1'b1;
        if (stat_i.done) begin
          state_d = bet_pkg::ST_PLACE;
        end
      end
      bet_pkg::ST_PLACE: begin
        ctl_o.place = 1'b1;
        state_d = bet_pkg::ST_DONE;
      end
      bet_pkg::ST_SCAN2: begin
        ctl_o.scan2 = 1'b1;
        if (stat_i.done) begin
          state_d = bet_pkg::ST_DONE;
        end
      end
      bet_pkg::ST_MUL: begin
        ctl_o.mul = 1'b1;
        state_d = bet_pkg::ST_DSTART;
      end
      bet_pkg::ST_DSTART: begin
        ctl_o.div_start = 1'b1;
        state_d = bet_pkg::ST_DIV;
      end
      bet_pkg::ST_DIV: begin
        if (stat_i.div_done) begin
          state_d = bet_pkg::ST_DONE;
        end
      end
      bet_pkg::ST_DONE: begin
        if (stat_i.out_free) begin
          ctl_o.finish = 1'b1;
          state_d = bet_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bet_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: design/bet_chk.sv
// Port-level checker for the breakpoint envelope table, bound to the top level.
// Depends on bet_pkg for status codes.
module bet_chk #(
  parameter int unsigned TableDepth = bet_pkg::TABLE_DEPTH
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_value,
  input logic [1:0]         out_status,
  input logic [6:0]         out_entries
);
  // Hold a result until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // One command in work: no new transfer right after one
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("command taken while busy");

  // Entry count never exceeds the table
  a_entries: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> 32'(out_entries) <= TableDepth)
    else $error("entry count past table depth");

  // A nonzero value only comes from evaluate, which reports ok
  a_value_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_value != 16'sd0 |-> out_status == bet_pkg::STS_OK)
    else $error("value with non-ok status");
endmodule

bind breakpoint_envelope_table_unit bet_chk #(
  .TableDepth (TableDepth)
) u_bet_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (cmd_i.valid),
  .in_ready    (cmd_i.ready),
  .out_valid   (res_o.valid),
  .out_ready   (res_o.ready),
  .out_value   (res_o.value),
  .out_status  (res_o.status),
  .out_entries (res_o.entries)
);

// File: verif/breakpoint_envelope_table_unit_tb.sv
// Testbench for breakpoint_envelope_table_unit: directed table, then random command
// streams checked against a behavioral model of the breakpoint table.
// Depends on bet_pkg and the bet_cmd_if / bet_res_if channel interfaces.
`timescale 1ns / 100ps

module breakpoint_envelope_table_unit_tb;

  typedef struct {
    logic [2:0]         op;
    logic [31:0]        frame;
    logic [31:0]        span;
    logic [1:0]         mask;
    logic signed [15:0] gain;
    bit                 typed;
    logic signed [15:0] x_value;
    logic [1:0]         x_status;
    logic [6:0]         x_entries;
  } cmd_row_t;

  typedef struct {
    logic signed [15:0] value;
    logic [1:0]         status;
    logic [6:0]         entries;
  } result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       type_enable_we_i = 1'b0;
  logic [1:0] type_enable_wdata_i = 2'd0;
  bit         failed = 1'b0;
  bit         hold_req = 1'b0;

  bet_cmd_if cmd_ch ();
  bet_res_if res_ch ();

  breakpoint_envelope_table_unit DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .type_enable_we_i   (type_enable_we_i),
    .type_enable_wdata_i(type_enable_wdata_i),
    .cmd_i              (cmd_ch.sink),
    .res_o              (res_ch.source)
  );

  always #4 clk_i = ~clk_i;

  // Model of the breakpoint table
  logic [31:0]        bp_frame [bet_pkg::TABLE_DEPTH];
  logic [1:0]         bp_type  [bet_pkg::TABLE_DEPTH];
  logic signed [15:0] bp_gain  [bet_pkg::TABLE_DEPTH];
  int                 bp_count = 0;
  logic [1:0]         eval_enable = 2'd3;
  result_t            pending_results[$];

  function automatic void remove_range(logic [31:0] f, longint end_f, logic [1:0] mask);
    int  w;
    bit  stopped;
    w = 0;
    stopped = 1'b0;
    for (int i = 0; i < bp_count; i++) begin
      if (!stopped && longint'(bp_frame[i]) > end_f) stopped = 1'b1;
      if (!stopped && bp_frame[i] >= f && (bp_type[i] & mask) != 0) continue;
      bp_frame[w] = bp_frame[i];
      bp_type[w]  = bp_type[i];
      bp_gain[w]  = bp_gain[i];
      w++;
    end
    bp_count = w;
  endfunction

  function automatic result_t envelope_apply(cmd_row_t it);
    result_t res;
    int      nxt, prv, pos;
    longint  end_f, nf, d, x, r;
    res.value = '0;
    res.status = bet_pkg::STS_OK;
    end_f = longint'(it.frame) + longint'(it.span);
    case (it.op)
      bet_pkg::CMD_INSERT: begin
        nxt = -1;
        for (int i = 0; i < bp_count; i++)
          if (nxt < 0 && bp_frame[i] >= it.frame && (bp_type[i] & it.mask) != 0) nxt = i;
        if (nxt >= 0 && bp_frame[nxt] == it.frame) res.status = bet_pkg::STS_DUP;
        else if (bp_count >= bet_pkg::TABLE_DEPTH) res.status = bet_pkg::STS_FULL;
        else begin
          pos = bp_count;
          for (int i = bp_count - 1; i >= 0; i--) if (bp_frame[i] >= it.frame) pos = i;
          for (int i = bp_count; i > pos; i--) begin
            bp_frame[i] = bp_frame[i-1];
            bp_type[i]  = bp_type[i-1];
            bp_gain[i]  = bp_gain[i-1];
          end
          bp_frame[pos] = it.frame;
          bp_type[pos]  = it.mask;
          bp_gain[pos]  = it.gain;
          bp_count++;
        end
      end
      bet_pkg::CMD_DEL_RANGE: remove_range(it.frame, end_f, it.mask);
      bet_pkg::CMD_INS_TIME: begin
        for (int i = 0; i < bp_count; i++) begin
          if (bp_frame[i] < it.frame || (bp_type[i] & it.mask) == 0) continue;
          nf = longint'(bp_frame[i]) + longint'(it.span);
          if (nf > 64'hFFFF_FFFF) begin
            nf = 64'hFFFF_FFFF;
            res.status = bet_pkg::STS_SAT;
          end
          bp_frame[i] = nf[31:0];
        end
      end
      bet_pkg::CMD_DEL_TIME: begin
        remove_range(it.frame, end_f, it.mask);
        for (int i = 0; i < bp_count; i++) begin
          if (bp_frame[i] < it.frame || (bp_type[i] & it.mask) == 0) continue;
          bp_frame[i] = bp_frame[i] > it.span ? bp_frame[i] - it.span : 32'd0;
        end
      end
      bet_pkg::CMD_INVERT: begin
        for (int i = 0; i < bp_count; i++) begin
          if (bp_frame[i] < it.frame) continue;
          if (longint'(bp_frame[i]) > end_f) break;
          if ((bp_type[i] & it.mask) != 0) begin
            if (bp_gain[i] == -16'sd32768) begin
              bp_gain[i] = 16'sd32767;
              res.status = bet_pkg::STS_SAT;
            end else bp_gain[i] = -bp_gain[i];
          end
        end
      end
      bet_pkg::CMD_EVAL: begin
        nxt = -1;
        prv = -1;
        // Previous point only counts up to the first matching point at or past frame
        for (int i = 0; i < bp_count; i++) begin
          if ((bp_type[i] & it.mask) == 0) continue;
          if (bp_frame[i] < it.frame) prv = i;
          else begin
            nxt = i;
            break;
          end
        end
        if ((eval_enable & it.mask) != 0 && nxt >= 0 && prv >= 0) begin
          d = longint'(bp_frame[nxt]) - longint'(bp_frame[prv]);
          if (d > 0) begin
            x = longint'(it.frame) - longint'(bp_frame[prv]);
            r = longint'(bp_gain[prv]) +
                ((longint'(bp_gain[nxt]) - longint'(bp_gain[prv])) * x) / d;
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            res.value = r[15:0];
          end
        end
      end
      default: ;
    endcase
    res.entries = bp_count[6:0];
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one command and hold it until the transfer
  task automatic send_cmd(cmd_row_t it);
    int      gap;
    result_t res;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.command   <= it.op;
    cmd_ch.frame     <= it.frame;
    cmd_ch.count     <= it.span;
    cmd_ch.type_mask <= it.mask;
    cmd_ch.gain      <= it.gain;
    do @(posedge clk_i); while (!cmd_ch.ready);
    res = envelope_apply(it);
    if (it.typed) begin
      res.value = it.x_value;
      res.status = it.x_status;
      res.entries = it.x_entries;
    end
    pending_results.push_back(res);
  endtask

  task automatic write_enable_mask(logic [1:0] v);
    cmd_ch.valid <= 1'b0;
    wait (pending_results.size() == 0);
    @(posedge clk_i);
    type_enable_we_i    <= 1'b1;
    type_enable_wdata_i <= v;
    @(posedge clk_i);
    type_enable_we_i <= 1'b0;
    eval_enable = v;
  endtask

  function automatic cmd_row_t random_cmd();
    cmd_row_t it;
    int       r;
    r = $urandom_range(0, 99);
    if (r < 35) it.op = bet_pkg::CMD_INSERT;
    else if (r < 65) it.op = bet_pkg::CMD_EVAL;
    else if (r < 73) it.op = bet_pkg::CMD_DEL_RANGE;
    else if (r < 81) it.op = bet_pkg::CMD_INS_TIME;
    else if (r < 89) it.op = bet_pkg::CMD_DEL_TIME;
    else if (r < 97) it.op = bet_pkg::CMD_INVERT;
    else it.op = 3'($urandom_range(6, 7));
    r = $urandom_range(0, 99);
    if (r < 85) it.frame = $urandom_range(0, 1000);
    else if (r < 95) it.frame = 32'hFFFF_FF00 + $urandom_range(0, 255);
    else it.frame = $urandom;
    r = $urandom_range(0, 99);
    if (r < 60) it.span = $urandom_range(0, 50);
    else if (r < 80) it.span = $urandom_range(0, 300);
    else if (r < 90) it.span = $urandom;
    else it.span = 32'hFFFF_FFFF - $urandom_range(0, 1000);
    it.mask = 2'($urandom_range(0, 3));
    it.gain = 16'($urandom);
    it.typed = 1'b0;
    return it;
  endfunction

  // Directed rows: op, frame, span, mask, gain, typed, value, status, entries
  cmd_row_t directed [] = '{
    '{bet_pkg::CMD_EVAL, 32'd100, 32'd0, 2'd3, 16'sd0, 1, 16'sd0, bet_pkg::STS_OK, 7'd0},
    '{bet_pkg::CMD_DEL_RANGE, 32'd0, 32'hFFFF_FFFF, 2'd3, 16'sd0, 1, 16'sd0,
      bet_pkg::STS_OK, 7'd0},
    '{3'd6, 32'd5, 32'd5, 2'd3, 16'sd1, 1, 16'sd0, bet_pkg::STS_OK, 7'd0},
    '{3'd7, 32'hFFFF_FFFF, 32'd5, 2'd3, 16'sd1, 1, 16'sd0, bet_pkg::STS_OK, 7'd0},
    '{bet_pkg::CMD_INSERT, 32'd100, 32'd0, 2'd1, 16'sd4096, 1, 16'sd0,
      bet_pkg::STS_OK, 7'd1},
    '{bet_pkg::CMD_INSERT, 32'd100, 32'd0, 2'd1, 16'sd5, 1, 16'sd0,
      bet_pkg::STS_DUP, 7'd1},
    '{bet_pkg::CMD_INSERT, 32'd100, 32'd0, 2'd2, -16'sd4096, 0, 16'sd0,
      bet_pkg::STS_OK, 7'd0},
    '{bet_pkg::CMD_INSERT, 32'd0, 32'd0, 2'd1, -16'sd32768, 0, 16'sd0,
      bet_pkg::STS_OK, 7'd0},
    '{bet_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'd0, 2'd1, 16'sd32767, 0, 16'sd0,
      bet_pkg::STS_OK, 7'd0},
    '{bet_pkg::CMD_INSERT, 32'd300, 32'd0, 2'd0, 16'sd7, 0, 16'sd0, bet_pkg::STS_OK, 7'd0},
    '{bet_pkg::CMD_EVAL, 32'd50, 32'd0, 2'd1, 16'sd0, 0, 16'sd0, bet_pkg::STS_OK, 7'd0},
    '{bet_pkg::CMD_EVAL, 32'd0, 32'd0, 2'd1, 16'sd0, 0, 16'sd0, bet_pkg::STS_OK, 7'd0},
    '{bet_pkg::CMD_EVAL, 32'hFFFF_FFFE, 32'd0, 2'd3, 16'sd0, 0, 16'sd0,
      bet_pkg::STS_OK, 7'd0},
    '{bet_pkg::CMD_EVAL, 32'd200, 32'd0, 2'd2, 16'sd0, 0, 16'sd0, bet_pkg::STS_OK, 7'd0},
    '{bet_pkg::CMD_INVERT, 32'd0, 32'hFFFF_FFFF, 2'd1, 16'sd0, 0, 16'sd0,
      bet_pkg::STS_OK, 7'd0},
    '{bet_pkg::CMD_INS_TIME, 32'd200, 32'hFFFF_FFFF, 2'd1, 16'sd0, 0, 16'sd0,
      bet_pkg::STS_OK, 7'd0},
    '{bet_pkg::CMD_DEL_TIME, 32'd50, 32'd100, 2'd3, 16'sd0, 0, 16'sd0,
      bet_pkg::STS_OK, 7'd0},
    '{bet_pkg::CMD_INS_TIME, 32'd0, 32'd0, 2'd0, 16'sd0, 0, 16'sd0, bet_pkg::STS_OK, 7'd0},
    '{bet_pkg::CMD_INSERT, 32'd5, 32'd0, 2'd3, 16'sd32767, 0, 16'sd0,
      bet_pkg::STS_OK, 7'd0},
    '{bet_pkg::CMD_EVAL, 32'd123, 32'd0, 2'd3, 16'sd0, 0, 16'sd0, bet_pkg::STS_OK, 7'd0},
    '{bet_pkg::CMD_DEL_RANGE, 32'd0, 32'hFFFF_FFFF, 2'd2, 16'sd0, 0, 16'sd0,
      bet_pkg::STS_OK, 7'd0},
    '{bet_pkg::CMD_DEL_TIME, 32'd0, 32'hFFFF_FFFF, 2'd3, 16'sd0, 0, 16'sd0,
      bet_pkg::STS_OK, 7'd0},
    '{bet_pkg::CMD_EVAL, 32'd0, 32'd0, 2'd0, 16'sd0, 0, 16'sd0, bet_pkg::STS_OK, 7'd0}
  };

  // Command stream
  initial begin
    cmd_row_t    it;
    logic [1:0]  modes [5];
    modes = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd3};
    cmd_ch.valid     = 1'b0;
    cmd_ch.command   = '0;
    cmd_ch.frame     = '0;
    cmd_ch.count     = '0;
    cmd_ch.type_mask = '0;
    cmd_ch.gain      = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[k]) send_cmd(directed[k]);
    for (int p = 0; p < 5; p++) begin
      write_enable_mask(modes[p]);
      // Fill past capacity to reach the table-full refusal
      if (p == 1)
        for (int k = 0; k < 72; k++) begin
          it = random_cmd();
          it.op = bet_pkg::CMD_INSERT;
          it.frame = $urandom_range(0, 5000);
          send_cmd(it);
        end
      if (p == 3) hold_req = 1'b1;
      for (int k = 0; k < 60; k++) send_cmd(random_cmd());
    end
    cmd_ch.valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (200) @(posedge clk_i);
    if (!failed) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  // Result side backpressure
  initial begin
    int gap;
    res_ch.ready = 1'b0;
    forever begin
      if (hold_req) begin
        res_ch.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          res_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        res_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result value=%0d status=%0d entries=%0d", $time,
                 res_ch.value, res_ch.status, res_ch.entries);
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        if (res_ch.value !== want.value) begin
          $display("%0t: value expected %0d actual %0d", $time, want.value, res_ch.value);
          failed = 1'b1;
        end
        if (res_ch.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, res_ch.status);
          failed = 1'b1;
        end
        if (res_ch.entries !== want.entries) begin
          $display("%0t: entries expected %0d actual %0d", $time, want.entries,
                   res_ch.entries);
          failed = 1'b1;
        end
      end
    end
  end

  // Run limit
  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: filelist.f
design/bet_pkg.sv
design/bet_if.sv
design/bet_div.sv
design/bet_dp.sv
design/bet_ctrl.sv
design/breakpoint_envelope_table_unit.sv
design/bet_chk.sv
verif/breakpoint_envelope_table_unit_tb.sv
